// File: rtl/awa_pkg.sv
// ----------------------------------------------------------------------------
// awa_pkg: shared definitions for the accelerometer window average block
// Field widths, saturation limits, register map and warning codes.
// ----------------------------------------------------------------------------
package awa_pkg;

    // Field widths.
    localparam int RAW_W   = 16;   // raw sensor counts
    localparam int ACC_W   = 14;   // signed acceleration, 8 fractional bits
    localparam int MAG_W   = 13;   // unsigned magnitude, 8 fractional bits
    localparam int SCALE_W = 16;   // lsb scale, 24 fractional bits
    localparam int THR_W   = 13;   // thresholds, 8 fractional bits
    localparam int SQ_W    = 26;   // sum of squares of two saturated values
    localparam int ROOT_W  = 13;   // integer part of the square root

    // The product raw * scale carries 24 fractional bits; keep 8 of them.
    localparam int SCALE_SHIFT = 16;
    localparam int SCALE_HALF  = 32768;

    // Saturation limits.
    localparam int ACC_LIMIT = 4560;
    localparam int MAG_LIMIT = 6450;

    // Configuration register map and reset values.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_LSB_SCALE    = 2'd0;
    localparam logic [1:0] REG_INSTANT_THR  = 2'd1;
    localparam logic [1:0] REG_AVERAGE_THR  = 2'd2;
    localparam logic [SCALE_W-1:0] LSB_SCALE_RST   = 16'd9118;
    localparam logic [THR_W-1:0]   INSTANT_THR_RST = 13'd512;
    localparam logic [THR_W-1:0]   AVERAGE_THR_RST = 13'd256;

    // Warning codes.
    localparam logic [1:0] IW_NONE  = 2'd0;
    localparam logic [1:0] IW_BRAKE = 2'd1;
    localparam logic [1:0] IW_ACCEL = 2'd2;
    localparam logic [1:0] AW_NONE  = 2'd0;
    localparam logic [1:0] AW_MAG   = 2'd1;
    localparam logic [1:0] AW_BRAKE = 2'd2;
    localparam logic [1:0] AW_ACCEL = 2'd3;

endpackage

// File: rtl/awa_mul.sv
// ----------------------------------------------------------------------------
// awa_mul: registered signed multiplier
// The single multiplier shared by scaling, squaring and averaging.
// ----------------------------------------------------------------------------
module awa_mul #(
    parameter int OP_W = 17
) (
    input  logic                       aclk,
    input  logic signed [OP_W-1:0]     op_a,
    input  logic signed [OP_W-1:0]     op_b,
    output logic signed [2*OP_W-1:0]   prod
);

    logic signed [2*OP_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/awa_isqrt.sv
// ----------------------------------------------------------------------------
// awa_isqrt: iterative integer square root, rounded to nearest
// Resolves one root bit per cycle, then applies a rounding step.
// ----------------------------------------------------------------------------
module awa_isqrt import awa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SQ_W-1:0]     radicand,
    output logic                done,
    output logic [ROOT_W:0]     root
);

    localparam int W     = SQ_W + 1;
    localparam int ITER  = SQ_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic             run_reg;
    logic             fin_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     pow_reg;
    logic [ROOT_W:0]  root_reg;
    logic [W-1:0]     trial;
    logic             fits;

    // One step of the digit-by-digit method: try subtracting acc + pow.
    always_comb begin
        trial = acc_reg + pow_reg;
        fits  = (rem_reg >= trial);
        if (fits) begin
            rem_next = rem_reg - trial;
            acc_next = (acc_reg >> 1) + pow_reg;
        end else begin
            rem_next = rem_reg;
            acc_next = acc_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= run_reg && (cnt_reg == '0);
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(ITER - 1);
            end else if (run_reg) begin
                if (cnt_reg == '0) begin
                    run_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= W'(radicand);
            acc_reg <= '0;
            pow_reg <= W'(1) << (2 * (ITER - 1));
        end else if (run_reg) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            pow_reg <= pow_reg >> 2;
        end
        // Round up when the remainder exceeds the root.
        if (fin_reg) begin
            root_reg <= acc_reg[ROOT_W:0] + (ROOT_W+1)'(rem_reg > acc_reg);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/accel_window_average_warn_top.sv
// ----------------------------------------------------------------------------
// accel_window_average_warn_top: accelerometer scaling, moving averages and
// warnings
// Scales x/y accelerometer counts, forms the planar magnitude and keeps
// windowed averages of all three with threshold warnings.
// ----------------------------------------------------------------------------
// Each input transfer carries one raw x/y reading in sensor counts. The block
// scales both axes to m/s^2 with 8 fractional bits (saturated to +/-4560),
// takes the rounded square root of the sum of squares as the magnitude
// (saturated to 6450), pushes all three values into windows of WINDOW_LEN
// entries with running sums, and sends one result transfer holding the
// current values, the three window averages (entries not yet filled count
// as zero, rounding ties away from zero) and the instant and average warning
// codes. The average warning compares the exact window sums against the
// threshold times WINDOW_LEN, so it does not depend on the rounding of the
// averages. Each item goes through the 13-step square root unit and seven
// passes through the one shared multiplier (two scalings, two squares,
// three reciprocal divisions) before its result is offered, and the block
// takes no new item until that result has moved to the output register.
// s_ready is high only while the block waits for an item, but a finished
// result sits in its own output register, so the next item is taken while
// the previous result still waits. Windows start cleared after reset without
// a clearing pass: each entry has a valid bit. The user must write the
// configuration registers through the APB port only while the block is idle
// (the block itself does not enforce this): lsb_scale at 0x0,
// instant_threshold at 0x4, average_threshold at 0x8; bits above each register's width are dropped.
// ----------------------------------------------------------------------------
module accel_window_average_warn_top import awa_pkg::*; #(
    parameter int WINDOW_LEN = 60
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // Input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [RAW_W-1:0] s_raw_x,
    input  logic signed [RAW_W-1:0] s_raw_y,
    // Result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [ACC_W-1:0] m_accel_x,
    output logic signed [ACC_W-1:0] m_accel_y,
    output logic [MAG_W-1:0]        m_accel_mag,
    output logic signed [ACC_W-1:0] m_avg_x,
    output logic signed [ACC_W-1:0] m_avg_y,
    output logic [MAG_W-1:0]        m_avg_mag,
    output logic [1:0]              m_instant_warning,
    output logic [1:0]              m_average_warning
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int HALF   = WINDOW_LEN / 2;
    // Signed sum of x or y values and unsigned sum of magnitudes.
    localparam int XSUM_W = $clog2(WINDOW_LEN * ACC_LIMIT + 1) + 1;
    localparam int MSUM_W = $clog2(WINDOW_LEN * MAG_LIMIT + 1);
    // Division by WINDOW_LEN as a multiplication by a rounded-up reciprocal;
    // with DIV_K = DIV_N + ceil(log2(WINDOW_LEN)) the quotient is exact for
    // every dividend below 2^DIV_N.
    localparam int DIV_N  = $clog2(WINDOW_LEN * MAG_LIMIT + HALF + 1);
    localparam int DIV_K  = DIV_N + $clog2(WINDOW_LEN);
    localparam logic [63:0] DIV_M = ((64'd1 << DIV_K) + 64'(WINDOW_LEN) - 64'd1)
                                    / 64'(WINDOW_LEN);
    localparam int MUL_W  = (DIV_N + 2 > RAW_W + 1) ? DIV_N + 2 : RAW_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    // Threshold times WINDOW_LEN, and a signed width that holds every
    // quantity of the average warning compare.
    localparam int THRW_W = THR_W + $clog2(WINDOW_LEN + 1);
    localparam int CMP_A  = (XSUM_W > MSUM_W + 1) ? XSUM_W : MSUM_W + 1;
    localparam int CMP_W  = ((CMP_A > THRW_W + 1) ? CMP_A : THRW_W + 1) + 1;

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,  // wait for an input transfer
        ST_SCX  = 13'b0000000000010,  // multiply raw x by the scale
        ST_SCY  = 13'b0000000000100,  // round x, multiply raw y by the scale
        ST_SQX  = 13'b0000000001000,  // round y, square x
        ST_SQY  = 13'b0000000010000,  // keep x squared, square y
        ST_SQS  = 13'b0000000100000,  // add squares, start the square root
        ST_ROOT = 13'b0000001000000,  // wait for the root
        ST_UPD  = 13'b0000010000000,  // window write and running sums
        ST_DVX  = 13'b0000100000000,  // divide x sum, form warnings
        ST_DVY  = 13'b0001000000000,  // x average, divide y sum
        ST_DVM  = 13'b0010000000000,  // y average, divide magnitude sum
        ST_DVE  = 13'b0100000000000,  // magnitude average
        ST_OUT  = 13'b1000000000000   // move the result to the output
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] scale_reg;
    logic [THR_W-1:0]   inst_thr_reg;
    logic [THR_W-1:0]   avg_thr_reg;
    logic               cfg_write;
    logic [1:0]         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= LSB_SCALE_RST;
            inst_thr_reg <= INSTANT_THR_RST;
            avg_thr_reg  <= AVERAGE_THR_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_LSB_SCALE:   scale_reg    <= pwdata[SCALE_W-1:0];
                REG_INSTANT_THR: inst_thr_reg <= pwdata[THR_W-1:0];
                REG_AVERAGE_THR: avg_thr_reg  <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_LSB_SCALE:   prdata = APB_DATA_W'(scale_reg);
            REG_INSTANT_THR: prdata = APB_DATA_W'(inst_thr_reg);
            REG_AVERAGE_THR: prdata = APB_DATA_W'(avg_thr_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------
    // Product raw * scale to 8 fractional bits, round half up, saturate.
    function automatic logic signed [ACC_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] q;
        q = (p + $signed(PROD_W'(SCALE_HALF))) >>> SCALE_SHIFT;
        if (q > $signed(PROD_W'(ACC_LIMIT))) begin
            return ACC_W'(ACC_LIMIT);
        end else if (q < -$signed(PROD_W'(ACC_LIMIT))) begin
            return ACC_W'(-ACC_LIMIT);
        end
        return q[ACC_W-1:0];
    endfunction

    // Apply the sign of the sum to a quotient magnitude and saturate.
    function automatic logic signed [ACC_W-1:0] avg_sat(
        input logic             neg,
        input logic [MAG_W-1:0] q
    );
        logic [ACC_W-1:0] m;
        m = (q > MAG_W'(ACC_LIMIT)) ? ACC_W'(ACC_LIMIT) : ACC_W'(q);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [RAW_W-1:0]  raw_x_reg, raw_y_reg;
    logic signed [ACC_W-1:0]  ax_reg, ay_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [MAG_W-1:0]         am_reg;
    logic signed [XSUM_W-1:0] x_sum_reg, y_sum_reg;
    logic [MSUM_W-1:0]        m_sum_reg;
    logic signed [ACC_W-1:0]  vx_reg, vy_reg;
    logic [MAG_W-1:0]         vm_reg;
    logic [1:0]               iw_reg, aw_reg;
    logic [POS_W-1:0]         pos_reg;

    // ------------------------------------------------------------------
    // Windows: one memory per value, read at the write position every
    // cycle; an entry that has never been written reads as zero.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] xwin_mem [WINDOW_LEN];
    logic signed [ACC_W-1:0] ywin_mem [WINDOW_LEN];
    logic [MAG_W-1:0]        mwin_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]   vld_reg;
    logic signed [ACC_W-1:0] xrd_reg, yrd_reg;
    logic [MAG_W-1:0]        mrd_reg;
    logic                    vrd_reg;
    logic signed [ACC_W-1:0] old_x, old_y;
    logic [MAG_W-1:0]        old_m;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            xwin_mem[pos_reg] <= ax_reg;
            ywin_mem[pos_reg] <= ay_reg;
            mwin_mem[pos_reg] <= am_reg;
        end
        xrd_reg <= xwin_mem[pos_reg];
        yrd_reg <= ywin_mem[pos_reg];
        mrd_reg <= mwin_mem[pos_reg];
        vrd_reg <= vld_reg[pos_reg];
    end

    assign old_x = vrd_reg ? xrd_reg : '0;
    assign old_y = vrd_reg ? yrd_reg : '0;
    assign old_m = vrd_reg ? mrd_reg : '0;

    // ------------------------------------------------------------------
    // Shared multiplier and operand selection
    // ------------------------------------------------------------------
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [XSUM_W-1:0]        x_abs, y_abs;
    logic [DIV_N-1:0]         x_num, y_num, m_num;
    logic signed [MUL_W-1:0]  recip;

    // Rounded dividends: |sum| + WINDOW_LEN/2.
    assign x_abs = x_sum_reg[XSUM_W-1] ? $unsigned(-x_sum_reg) : $unsigned(x_sum_reg);
    assign y_abs = y_sum_reg[XSUM_W-1] ? $unsigned(-y_sum_reg) : $unsigned(y_sum_reg);
    assign x_num = DIV_N'(x_abs) + DIV_N'(HALF);
    assign y_num = DIV_N'(y_abs) + DIV_N'(HALF);
    assign m_num = DIV_N'(m_sum_reg) + DIV_N'(HALF);
    assign recip = $signed(MUL_W'(DIV_M));

    always_comb begin
        case (state_reg)
            ST_SCX: begin
                mul_a = MUL_W'(raw_x_reg);
                mul_b = $signed(MUL_W'(scale_reg));
            end
            ST_SCY: begin
                mul_a = MUL_W'(raw_y_reg);
                mul_b = $signed(MUL_W'(scale_reg));
            end
            ST_SQX: begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            ST_SQY: begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
            end
            ST_DVX: begin
                mul_a = $signed(MUL_W'(x_num));
                mul_b = recip;
            end
            ST_DVY: begin
                mul_a = $signed(MUL_W'(y_num));
                mul_b = recip;
            end
            ST_DVM: begin
                mul_a = $signed(MUL_W'(m_num));
                mul_b = recip;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    awa_mul #(
        .OP_W (MUL_W)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    logic [MAG_W-1:0] quot;
    assign quot = prod[DIV_K +: MAG_W];

    // ------------------------------------------------------------------
    // Square root unit
    // ------------------------------------------------------------------
    logic              sqrt_start;
    logic              sqrt_done;
    logic [SQ_W-1:0]   sqrt_in;
    logic [ROOT_W:0]   sqrt_root;

    assign sqrt_start = (state_reg == ST_SQS);
    assign sqrt_in    = sq_reg + prod[SQ_W-1:0];

    awa_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ------------------------------------------------------------------
    // Warnings, evaluated on the updated sums
    // ------------------------------------------------------------------
    logic signed [ACC_W:0]  ax_ext, it_ext;
    logic signed [CMP_W-1:0] at_ext, xs_ext, ms_ext;
    logic [1:0]              iw_next, aw_next;

    assign ax_ext = (ACC_W+1)'(ax_reg);
    assign it_ext = $signed((ACC_W+1)'(inst_thr_reg));
    assign at_ext = $signed(CMP_W'(avg_thr_reg) * CMP_W'(WINDOW_LEN));
    assign xs_ext = CMP_W'(x_sum_reg);
    assign ms_ext = $signed(CMP_W'(m_sum_reg));

    always_comb begin
        if (ax_ext < -it_ext) begin
            iw_next = IW_BRAKE;
        end else if (ax_ext > it_ext) begin
            iw_next = IW_ACCEL;
        end else begin
            iw_next = IW_NONE;
        end
        if (ms_ext > at_ext) begin
            if (xs_ext < -at_ext) begin
                aw_next = AW_BRAKE;
            end else if (xs_ext > at_ext) begin
                aw_next = AW_ACCEL;
            end else begin
                aw_next = AW_MAG;
            end
        end else begin
            aw_next = AW_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        case (state_reg)
            ST_IDLE: state_next = s_valid ? ST_SCX : ST_IDLE;
            ST_SCX:  state_next = ST_SCY;
            ST_SCY:  state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SQS;
            ST_SQS:  state_next = ST_ROOT;
            ST_ROOT: state_next = sqrt_done ? ST_UPD : ST_ROOT;
            ST_UPD:  state_next = ST_DVX;
            ST_DVX:  state_next = ST_DVY;
            ST_DVY:  state_next = ST_DVM;
            ST_DVM:  state_next = ST_DVE;
            ST_DVE:  state_next = ST_OUT;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            vld_reg   <= '0;
            x_sum_reg <= '0;
            y_sum_reg <= '0;
            m_sum_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_UPD) begin
                vld_reg[pos_reg] <= 1'b1;
                x_sum_reg <= x_sum_reg + XSUM_W'(ax_reg) - XSUM_W'(old_x);
                y_sum_reg <= y_sum_reg + XSUM_W'(ay_reg) - XSUM_W'(old_y);
                m_sum_reg <= m_sum_reg + MSUM_W'(am_reg) - MSUM_W'(old_m);
                if (pos_reg == POS_W'(WINDOW_LEN - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // Item payload.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                raw_x_reg <= s_raw_x;
                raw_y_reg <= s_raw_y;
            end
            ST_SCY:  ax_reg <= scale_sat(prod);
            ST_SQX:  ay_reg <= scale_sat(prod);
            ST_SQY:  sq_reg <= prod[SQ_W-1:0];
            ST_ROOT: begin
                if (sqrt_root > (ROOT_W+1)'(MAG_LIMIT)) begin
                    am_reg <= MAG_W'(MAG_LIMIT);
                end else begin
                    am_reg <= sqrt_root[MAG_W-1:0];
                end
            end
            ST_DVX: begin
                iw_reg <= iw_next;
                aw_reg <= aw_next;
            end
            ST_DVY:  vx_reg <= avg_sat(x_sum_reg[XSUM_W-1], quot);
            ST_DVM:  vy_reg <= avg_sat(y_sum_reg[XSUM_W-1], quot);
            ST_DVE:  vm_reg <= (quot > MAG_W'(MAG_LIMIT)) ? MAG_W'(MAG_LIMIT) : quot;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] m_accel_x_reg, m_accel_y_reg;
    logic signed [ACC_W-1:0] m_avg_x_reg, m_avg_y_reg;
    logic [MAG_W-1:0]        m_accel_mag_reg, m_avg_mag_reg;
    logic [1:0]              m_iw_reg, m_aw_reg;
    logic                    out_load;

    assign out_load = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_accel_x_reg   <= ax_reg;
            m_accel_y_reg   <= ay_reg;
            m_accel_mag_reg <= am_reg;
            m_avg_x_reg     <= vx_reg;
            m_avg_y_reg     <= vy_reg;
            m_avg_mag_reg   <= vm_reg;
            m_iw_reg        <= iw_reg;
            m_aw_reg        <= aw_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accel_x         = m_accel_x_reg;
    assign m_accel_y         = m_accel_y_reg;
    assign m_accel_mag       = m_accel_mag_reg;
    assign m_avg_x           = m_avg_x_reg;
    assign m_avg_y           = m_avg_y_reg;
    assign m_avg_mag         = m_avg_mag_reg;
    assign m_instant_warning = m_iw_reg;
    assign m_average_warning = m_aw_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SCX)
        else $error("input transfer did not start the sequence");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result offered outside the output step");

    a_root_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its wait step");

    a_pos_moves_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (pos_reg != $past(pos_reg)) |-> $past(state_reg == ST_UPD))
        else $error("window position moved without a window update");

endmodule

// File: tb/sv/accel_window_average_warn_top_tb.sv
// ----------------------------------------------------------------------------
// accel_window_average_warn_top_tb: self-checking bench for the window block
// Predicts every result of the accelerometer window average block from its
// own model of scaling, magnitude, windows and warnings, and checks each
// output transfer against it under several register settings and idling.
// ----------------------------------------------------------------------------
module accel_window_average_warn_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import awa_pkg::*;

    localparam int WINDOW_LEN       = 60;
    localparam int HOLD_CYCLES      = 40;    // a little more than one item's latency
    localparam int QUIET_LIMIT      = 4000;  // cycles without any transfer before giving up
    localparam int RANDOM_PER_PHASE = 210;
    localparam int NUM_PHASES       = 8;
    localparam int MAX_REPORTS      = 10;

    // Address slot 0xC holds no register; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One output transfer, laid out like the result ports.
    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic [MAG_W-1:0]        accel_mag;
        logic signed [ACC_W-1:0] avg_x;
        logic signed [ACC_W-1:0] avg_y;
        logic [MAG_W-1:0]        avg_mag;
        logic [1:0]              instant_warning;
        logic [1:0]              average_warning;
    } accel_result_t;

    // Keeps a private copy of the registers and the three windows, works out
    // the result of every accepted reading and matches it against the output.
    class accel_window_tracker;
        logic [SCALE_W-1:0] scale;
        logic [THR_W-1:0]   inst_thr;
        logic [THR_W-1:0]   avg_thr;
        int                 x_hist [WINDOW_LEN];
        int                 y_hist [WINDOW_LEN];
        int                 mag_hist [WINDOW_LEN];
        int                 wpos;
        int                 x_sum;
        int                 y_sum;
        int                 mag_sum;
        accel_result_t      pending_results [$];
        int                 errors;
        int                 result_count;

        function new();
            scale    = LSB_SCALE_RST;
            inst_thr = INSTANT_THR_RST;
            avg_thr  = AVERAGE_THR_RST;
            foreach (x_hist[i]) begin
                x_hist[i]   = 0;
                y_hist[i]   = 0;
                mag_hist[i] = 0;
            end
            wpos         = 0;
            x_sum        = 0;
            y_sum        = 0;
            mag_sum      = 0;
            errors       = 0;
            result_count = 0;
        endfunction

        function void log_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_LSB_SCALE:   scale    = value[SCALE_W-1:0];
                REG_INSTANT_THR: inst_thr = value[THR_W-1:0];
                REG_AVERAGE_THR: avg_thr  = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_LSB_SCALE:   return 32'(scale);
                REG_INSTANT_THR: return 32'(inst_thr);
                REG_AVERAGE_THR: return 32'(avg_thr);
                default:         return 32'd0;
            endcase
        endfunction

        function int limit_to(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // raw * scale / 2^16, rounded to nearest with ties upward.
        function int scale_count(logic signed [RAW_W-1:0] raw);
            longint prod;
            prod = longint'(raw) * longint'({1'b0, scale});
            return limit_to(int'((prod + 32768) >>> SCALE_SHIFT), -ACC_LIMIT, ACC_LIMIT);
        endfunction

        // Bitwise square root, then rounded to nearest.
        function int unsigned root_round(int unsigned s);
            int unsigned r;
            int unsigned b;
            int unsigned n;
            r = 0;
            b = 32'h4000_0000;
            n = s;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (s - r * r > r) r = r + 1;
            return r;
        endfunction

        // Window sum over its length, ties away from zero.
        function int window_mean(int s);
            if (s < 0) return -((-s + WINDOW_LEN / 2) / WINDOW_LEN);
            return (s + WINDOW_LEN / 2) / WINDOW_LEN;
        endfunction

        function void take_reading(logic signed [RAW_W-1:0] rx, logic signed [RAW_W-1:0] ry);
            accel_result_t e;
            int            ax;
            int            ay;
            int            am;
            int            vx;
            int            vy;
            int            vm;
            int            span;
            ax = scale_count(rx);
            ay = scale_count(ry);
            am = int'(root_round(ax * ax + ay * ay));
            if (am > MAG_LIMIT) am = MAG_LIMIT;

            // The new sample goes into the windows before the means are taken.
            x_sum   += ax - x_hist[wpos];
            y_sum   += ay - y_hist[wpos];
            mag_sum += am - mag_hist[wpos];
            x_hist[wpos]   = ax;
            y_hist[wpos]   = ay;
            mag_hist[wpos] = am;
            wpos = (wpos + 1) % WINDOW_LEN;

            vx = limit_to(window_mean(x_sum), -ACC_LIMIT, ACC_LIMIT);
            vy = limit_to(window_mean(y_sum), -ACC_LIMIT, ACC_LIMIT);
            vm = limit_to(window_mean(mag_sum), 0, MAG_LIMIT);

            e.accel_x   = ax[ACC_W-1:0];
            e.accel_y   = ay[ACC_W-1:0];
            e.accel_mag = am[MAG_W-1:0];
            e.avg_x     = vx[ACC_W-1:0];
            e.avg_y     = vy[ACC_W-1:0];
            e.avg_mag   = vm[MAG_W-1:0];

            if (ax < -int'(inst_thr))     e.instant_warning = IW_BRAKE;
            else if (ax > int'(inst_thr)) e.instant_warning = IW_ACCEL;
            else                          e.instant_warning = IW_NONE;

            // The average warnings use the exact sums, not the rounded means.
            span = int'(avg_thr) * WINDOW_LEN;
            e.average_warning = AW_NONE;
            if (mag_sum > span) begin
                e.average_warning = AW_MAG;
                if (x_sum < -span)     e.average_warning = AW_BRAKE;
                else if (x_sum > span) e.average_warning = AW_ACCEL;
            end
            pending_results.push_back(e);
        endfunction

        function string show(accel_result_t r);
            return $sformatf("x=%0d y=%0d mag=%0d avg_x=%0d avg_y=%0d avg_mag=%0d iw=%0d aw=%0d",
                             r.accel_x, r.accel_y, r.accel_mag, r.avg_x, r.avg_y,
                             r.avg_mag, r.instant_warning, r.average_warning);
        endfunction

        function void match_result(accel_result_t got);
            accel_result_t want;
            result_count++;
            if (pending_results.size() == 0) begin
                log_error($sformatf("result %0d arrived with none expected: %s",
                                    result_count, show(got)));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                log_error($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                    result_count, show(want), show(got)));
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [RAW_W-1:0] s_raw_x = '0;
    logic signed [RAW_W-1:0] s_raw_y = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [ACC_W-1:0] m_accel_x;
    logic signed [ACC_W-1:0] m_accel_y;
    logic [MAG_W-1:0]        m_accel_mag;
    logic signed [ACC_W-1:0] m_avg_x;
    logic signed [ACC_W-1:0] m_avg_y;
    logic [MAG_W-1:0]        m_avg_mag;
    logic [1:0]              m_instant_warning;
    logic [1:0]              m_average_warning;

    accel_window_tracker board;

    // Chance per cycle, in percent, that the sender holds back or the
    // receiver stalls; set per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    // Directed readings: zero, the corners of both fields, single counts,
    // the instant threshold edge at reset scale, and alternating bit patterns.
    logic signed [RAW_W-1:0] dir_x [14] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                            16'sh8000, 16'sh0001, 16'sh0000, 16'shFFFF,
                                            16'sd3680, 16'sd3688, -16'sd3680, -16'sd3688,
                                            16'sh5555, 16'shAAAA};
    logic signed [RAW_W-1:0] dir_y [14] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                                            16'sh7FFF, 16'sh0000, 16'shFFFF, 16'shFFFF,
                                            16'sh0000, 16'sh0010, 16'sh0000, -16'sd16,
                                            16'shAAAA, 16'sh5555};
    // With a scale of exactly one half, odd counts land on rounding ties.
    logic signed [RAW_W-1:0] tie_x [5] = '{16'sd1, -16'sd1, 16'sd3, -16'sd3, 16'sd0};
    logic signed [RAW_W-1:0] tie_y [5] = '{-16'sd1, 16'sd1, -16'sd3, 16'sd3, 16'sh7FFF};
    logic signed [RAW_W-1:0] corner_vals [8] = '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000,
                                                 16'sh0001, 16'sh7FFE, 16'sh7FFF, 16'sh4000};

    accel_window_average_warn_top #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_raw_x           (s_raw_x),
        .s_raw_y           (s_raw_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accel_x         (m_accel_x),
        .m_accel_y         (m_accel_y),
        .m_accel_mag       (m_accel_mag),
        .m_avg_x           (m_avg_x),
        .m_avg_y           (m_avg_y),
        .m_avg_mag         (m_avg_mag),
        .m_instant_warning (m_instant_warning),
        .m_average_warning (m_average_warning)
    );

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side. All outputs are sampled at the rising edge, before any
    // register of the block has taken its new value, so the check sees the
    // values that made up the transfer. The receiver's ready is decided for
    // the next cycle here as well: short random stalls with the odd long one.
    always @(posedge aclk) begin : result_side
        accel_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.accel_x         = m_accel_x;
            seen.accel_y         = m_accel_y;
            seen.accel_mag       = m_accel_mag;
            seen.avg_x           = m_avg_x;
            seen.avg_y           = m_avg_y;
            seen.avg_mag         = m_avg_mag;
            seen.instant_warning = m_instant_warning;
            seen.average_warning = m_average_warning;
            board.match_result(seen);
        end

        // Any transfer on either channel counts as progress for the watchdog.
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end

        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_stall_pct > 0 && $urandom_range(63) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(60);
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The run is stuck if nothing has moved for far longer than the slowest
    // legal item could take.
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [RAW_W-1:0] sat16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[RAW_W-1:0];
    endfunction

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    // Offers one reading and returns at the edge where the transfer happens,
    // with s_valid still high. A gap, when one is rolled, lowers valid first;
    // otherwise the next reading follows back to back.
    task automatic send_item(input logic signed [RAW_W-1:0] rx, input logic signed [RAW_W-1:0] ry);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (send_idle_pct > 0 && $urandom_range(15) == 0) gap += $urandom_range(1, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_x <= rx;
        s_raw_y <= ry;
        do @(posedge aclk); while (!s_ready);
        board.take_reading(rx, ry);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Half of the writes carry junk above the register width, which the block
    // must drop. Every real register is read back after the write.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] wdata;
        logic [31:0] rd;
        int          width;
        width = (idx == REG_LSB_SCALE) ? SCALE_W : THR_W;
        wdata = value;
        if ($urandom_range(1) == 1) wdata = wdata | ($urandom << width);
        apb_write(idx, wdata);
        board.write_reg(idx, wdata);
        if (idx != REG_UNUSED) begin
            apb_read(idx, rd);
            if (rd !== board.reg_value(idx)) begin
                board.log_error($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                                          idx, rd, board.reg_value(idx)));
            end
        end
    endtask

    // Waits for every outstanding result, then gives the block time to go
    // fully idle before registers may be touched.
    task automatic settle();
        while (board.pending() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_phase(input int ph);
        logic [31:0] sc;
        logic [31:0] it;
        logic [31:0] at;
        case (ph)
            0: begin sc = LSB_SCALE_RST; it = $urandom_range(0, 4600); at = $urandom_range(0, 4000); end
            1: begin sc = 32'd65535; it = 32'd0;    at = 32'd0;    end
            2: begin sc = 32'd0;     it = 32'd8191; at = 32'd8191; end
            3: begin
                sc = $urandom_range(0, 65535);
                it = $urandom_range(0, 8191);
                at = $urandom_range(0, 8191);
            end
            4: begin
                sc = $urandom_range(4000, 20000);
                it = $urandom_range(0, 3000);
                at = $urandom_range(0, 3000);
            end
            5: begin
                sc = $urandom_range(0, 65535);
                it = $urandom_range(0, 1500);
                at = $urandom_range(0, 1500);
            end
            6: begin sc = 32'd65535; it = 32'd8191; at = $urandom_range(0, 6450); end
            default: begin sc = LSB_SCALE_RST; it = INSTANT_THR_RST; at = AVERAGE_THR_RST; end
        endcase
        write_register(REG_LSB_SCALE, sc);
        write_register(REG_INSTANT_THR, it);
        write_register(REG_AVERAGE_THR, at);
        write_register(REG_UNUSED, $urandom);
    endtask

    // Random readings in segments. Steady runs dominate, since only a window
    // that holds many samples of one sign can push the average warnings past
    // their thresholds; the rest is full-range noise, small values, corner
    // counts and readings placed right at the instant threshold.
    task automatic run_random(input int count);
        int                      left;
        int                      kind;
        int                      len;
        int                      cx;
        int                      cy;
        int                      spread;
        int                      base;
        int                      j;
        logic signed [RAW_W-1:0] rx;
        logic signed [RAW_W-1:0] ry;
        left = count;
        while (left > 0) begin
            kind   = $urandom_range(0, 9);
            cx     = int'($urandom_range(0, 65535)) - 32768;
            cy     = int'($urandom_range(0, 65535)) - 32768;
            spread = $urandom_range(0, 2000);
            if (board.scale == 0) base = 0;
            else base = int'((longint'(board.inst_thr) * 65536) / board.scale);
            case (kind)
                0, 1:       len = $urandom_range(1, 10);
                2, 3, 4, 5: len = $urandom_range(20, 90);
                6, 7:       len = $urandom_range(1, 20);
                8:          len = $urandom_range(1, 8);
                default:    len = $urandom_range(1, 10);
            endcase
            for (j = 0; j < len && left > 0; j++) begin
                case (kind)
                    0, 1: begin
                        rx = RAW_W'($urandom);
                        ry = RAW_W'($urandom);
                    end
                    2, 3, 4, 5: begin
                        rx = sat16(cx + int'($urandom_range(0, 2 * spread)) - spread);
                        ry = sat16(cy + int'($urandom_range(0, 2 * spread)) - spread);
                    end
                    6, 7: begin
                        rx = sat16(int'($urandom_range(0, 4000)) - 2000);
                        ry = sat16(int'($urandom_range(0, 4000)) - 2000);
                    end
                    8: begin
                        rx = corner_vals[$urandom_range(0, 7)];
                        ry = corner_vals[$urandom_range(0, 7)];
                    end
                    default: begin
                        rx = sat16(($urandom_range(1) ? base : -base) + int'($urandom_range(0, 6)) - 3);
                        ry = RAW_W'($urandom);
                    end
                endcase
                send_item(rx, ry);
                left--;
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int ph;
        board = new();

        // Reset is held at the start and released once.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset register values, then the rounding
        // ties of the scaling with a scale of exactly one half.
        set_idle(0);
        for (i = 0; i < 14; i++) send_item(dir_x[i], dir_y[i]);
        s_valid <= 1'b0;
        settle();
        write_register(REG_LSB_SCALE, 32'd32768);
        for (i = 0; i < 5; i++) send_item(tie_x[i], tie_y[i]);
        s_valid <= 1'b0;
        settle();

        // Random phases, each with its own register setting and idling mode.
        // The windows carry over from phase to phase.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            configure_phase(ph);
            set_idle(ph % 4);
            run_random(RANDOM_PER_PHASE);
            s_valid <= 1'b0;
            settle();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
